// ===== rtl/slotted_latency_statistics_defines.svh =====
// Assertion macros used by the RTL.
`ifndef SLOTTED_LATENCY_STATISTICS_DEFINES_SVH
`define SLOTTED_LATENCY_STATISTICS_DEFINES_SVH

// Same-cycle implication.
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slt_pkg.sv =====
`timescale 1ns / 1ps
package slt_pkg;

    localparam int DEF_THREADS = 32;
    localparam int DEF_RECORDS = 128;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_IDLE = 1'b1;

    localparam logic [31:0] FREQ_RESET = 32'd10000000;

    // ticks * 1e6 needs 64 + 20 bits
    localparam int          US_W      = 20;
    localparam logic [US_W-1:0] US_PER_S = 20'd1000000;
    localparam int          PROD_W    = 64 + US_W;

    localparam logic [62:0] MAX63 = '1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  thread_index;
        logic [6:0]  record_index;
        logic [62:0] timestamp;
    } t_item;

    typedef struct packed {
        logic               status;
        logic signed [63:0] average_us;
        logic [62:0]        minimum_us;
        logic [62:0]        maximum_us;
        logic [31:0]        call_count;
    } t_result;

    typedef struct packed {
        logic        active;
        logic [62:0] start_stamp;
        logic [63:0] total_ticks;
        logic [62:0] min_ticks;
        logic [62:0] max_ticks;
        logic [31:0] pair_count;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

endpackage

// ===== rtl/slt_ram.sv =====
`timescale 1ns / 1ps
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/slt_conv.sv =====
`timescale 1ns / 1ps
// Tick to microsecond conversion: q = (x * 1e6) / freq, optionally / div.
// Shift-add multiply, then restoring division one quotient bit per cycle.
module slt_conv import slt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_x,
    input  logic [31:0]       i_freq,
    input  logic [31:0]       i_div,
    input  logic              i_second,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quot
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV1 = 2'd2;
    localparam logic [1:0] P_DIV2 = 2'd3;
    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [1:0]        r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [PROD_W-1:0] r_mcand;
    logic [US_W-1:0]   r_mplier;
    logic [PROD_W-1:0] r_acc;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [31:0]       r_div;
    logic              r_second;

    logic [32:0] rem_sh;
    logic [32:0] rem_diff;
    logic        ge;
    logic [31:0] rem_nx;
    logic        mul_last;
    logic        div_last;

    assign rem_sh   = {r_rem, r_acc[PROD_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign ge       = (rem_sh >= {1'b0, r_den});
    assign rem_nx   = ge ? rem_diff[31:0] : rem_sh[31:0];
    assign mul_last = (r_cnt == CNT_W'(US_W - 1));
    assign div_last = (r_cnt == CNT_W'(PROD_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_MUL;
                        r_cnt   <= '0;
                    end
                end
                P_MUL: begin
                    r_cnt <= mul_last ? '0 : r_cnt + 1'b1;
                    if (mul_last) begin
                        r_phase <= P_DIV1;
                    end
                end
                default: begin
                    r_cnt <= div_last ? '0 : r_cnt + 1'b1;
                    if (div_last) begin
                        if (r_phase == P_DIV1 && r_second) begin
                            r_phase <= P_DIV2;
                        end else begin
                            r_phase <= P_IDLE;
                            r_done  <= 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    r_mcand  <= PROD_W'(i_x);
                    r_mplier <= US_PER_S;
                    r_acc    <= '0;
                    r_den    <= i_freq;
                    r_div    <= i_div;
                    r_second <= i_second;
                end
            end
            P_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
                r_rem    <= '0;
            end
            default: begin
                r_acc <= {r_acc[PROD_W-2:0], ge};
                if (div_last && r_phase == P_DIV1) begin
                    r_rem <= '0;
                    r_den <= r_div;
                end else begin
                    r_rem <= rem_nx;
                end
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

// ===== rtl/slotted_latency_statistics.sv =====
`timescale 1ns / 1ps
// Per-slot latency monitor (min / max / trimmed average), one slot per
// thread and record index, all slot state in one single-port-write RAM.
// An item is taken when start is high and busy is low; its single result
// appears on o_result for exactly one cycle with o_done and cannot be held
// off, so the consumer must register it. Item cost, set by the slot RAM's
// read-modify-write and by the shared serial converter: start and end read
// the slot and write it back (an inactive end only reads), a read of an
// active slot runs three conversions of 20 multiply steps plus 84 divide
// steps each, the average taking a second 84-step divide, and clear writes
// every slot. After reset a clearing pass over all THREADS*RECORDS slots
// runs with busy high; configuration writes are always taken.
`include "slotted_latency_statistics_defines.svh"
module slotted_latency_statistics import slt_pkg::*; #(
    parameter int THREADS = DEF_THREADS,
    parameter int RECORDS = DEF_RECORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_done,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int SLOTS  = THREADS * RECORDS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_EXEC  = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_CAVG  = 4'd6;
    localparam logic [3:0] S_CMIN  = 4'd7;
    localparam logic [3:0] S_CMAX  = 4'd8;

    function automatic logic [62:0] sat63(input logic [PROD_W-1:0] q);
        sat63 = (|q[PROD_W-1:63]) ? MAX63 : q[62:0];
    endfunction

    function automatic logic [63:0] sat_avg(input logic neg, input logic [PROD_W-1:0] q);
        logic over_pos;
        logic over_neg;
        over_pos = |q[PROD_W-1:63];
        over_neg = (|q[PROD_W-1:64]) || (q[63] && (|q[62:0]));
        if (!neg) begin
            sat_avg = over_pos ? {1'b0, MAX63} : q[63:0];
        end else begin
            sat_avg = over_neg ? {1'b1, 63'd0} : (64'd0 - q[63:0]);
        end
    endfunction

    logic [3:0]        r_state,  n_state;
    t_item             r_item,   n_item;
    logic [SLOT_W-1:0] r_addr,   n_addr;
    logic [SLOT_W-1:0] r_sweep,  n_sweep;
    logic              r_clr,    n_clr;
    t_slot             r_word,   n_word;
    logic [62:0]       r_delta,  n_delta;
    logic [63:0]       r_sum,    n_sum;
    logic              r_neg,    n_neg;
    t_result           r_res,    n_res;
    logic              r_done,   n_done;
    logic [31:0]       r_freq;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_slot             ram_wdata;
    logic [SLOT_BITS-1:0] ram_rdata;
    t_slot             rd_word;

    logic              c_start;
    logic [63:0]       c_x;
    logic [31:0]       c_div;
    logic              c_second;
    logic              c_done;
    logic [PROD_W-1:0] c_quot;
    logic [31:0]       freq_nz;

    logic [31:0]       slot_lin;
    logic              in_range;
    logic [64:0]       tot_add;
    logic              tot_neg;
    logic [63:0]       tot_mag;
    t_slot             upd_word;

    assign rd_word  = t_slot'(ram_rdata);
    assign freq_nz  = (r_freq == 32'd0) ? 32'd1 : r_freq;
    assign slot_lin = 32'(i_item.thread_index) * 32'(RECORDS) + 32'(i_item.record_index);
    assign in_range = (32'(i_item.thread_index) < 32'(THREADS))
                   && (32'(i_item.record_index) < 32'(RECORDS));

    // end-event update, saturating total and count
    assign tot_add = {1'b0, r_word.total_ticks} + 65'(r_delta);
    always_comb begin
        upd_word = r_word;
        upd_word.total_ticks = tot_add[64] ? '1 : tot_add[63:0];
        if (r_delta < r_word.min_ticks) begin
            upd_word.min_ticks = r_delta;
        end
        if (r_delta > r_word.max_ticks) begin
            upd_word.max_ticks = r_delta;
        end
        if (r_word.pair_count != '1) begin
            upd_word.pair_count = r_word.pair_count + 32'd1;
        end
    end

    // trimmed average: |total - (min + max)| with sign kept aside
    assign tot_neg = (r_word.total_ticks < r_sum);
    assign tot_mag = tot_neg ? (r_sum - r_word.total_ticks) : (r_word.total_ticks - r_sum);

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_addr   = r_addr;
        n_sweep  = r_sweep;
        n_clr    = r_clr;
        n_word   = r_word;
        n_delta  = r_delta;
        n_sum    = r_sum;
        n_neg    = r_neg;
        n_res    = r_res;
        n_done   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        c_start  = 1'b0;
        c_x      = '0;
        c_div    = 32'd1;
        c_second = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    n_res  = '0;
                    if (i_item.kind == KIND_CLEAR) begin
                        n_sweep = '0;
                        n_clr   = 1'b1;
                        n_state = S_SWEEP;
                    end else if (!in_range) begin
                        n_res.status = ST_IDLE;
                        n_done       = 1'b1;
                    end else begin
                        n_addr  = slot_lin[SLOT_W-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                if (r_sweep == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                    n_done  = r_clr;
                    n_clr   = 1'b0;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_RD: begin
                // RAM read in flight
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_word = rd_word;
                unique case (r_item.kind)
                    KIND_START: begin
                        ram_we    = 1'b1;
                        ram_wdata = rd_word;
                        if (!rd_word.active) begin
                            ram_wdata.active      = 1'b1;
                            ram_wdata.total_ticks = '0;
                            ram_wdata.min_ticks   = MAX63;
                            ram_wdata.max_ticks   = '0;
                            ram_wdata.pair_count  = '0;
                        end
                        ram_wdata.start_stamp = r_item.timestamp;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    KIND_END: begin
                        n_delta = r_item.timestamp - rd_word.start_stamp;
                        if (!rd_word.active) begin
                            n_res.status = ST_IDLE;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_UPD;
                        end
                    end
                    KIND_READ: begin
                        n_sum = {1'b0, rd_word.min_ticks} + {1'b0, rd_word.max_ticks};
                        if (!rd_word.active) begin
                            n_res.status = ST_IDLE;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_PREP;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_UPD: begin
                ram_we    = 1'b1;
                ram_wdata = upd_word;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_PREP: begin
                n_neg    = tot_neg;
                c_start  = 1'b1;
                c_x      = tot_mag;
                c_second = 1'b1;
                c_div    = (r_word.pair_count > 32'd3) ? (r_word.pair_count - 32'd2) : 32'd1;
                n_state  = S_CAVG;
            end
            S_CAVG: begin
                if (c_done) begin
                    n_res.average_us = sat_avg(r_neg, c_quot);
                    c_start = 1'b1;
                    c_x     = {1'b0, r_word.min_ticks};
                    n_state = S_CMIN;
                end
            end
            S_CMIN: begin
                if (c_done) begin
                    n_res.minimum_us = sat63(c_quot);
                    c_start = 1'b1;
                    c_x     = {1'b0, r_word.max_ticks};
                    n_state = S_CMAX;
                end
            end
            S_CMAX: begin
                if (c_done) begin
                    n_res.maximum_us = sat63(c_quot);
                    n_res.call_count = r_word.pair_count;
                    n_res.status     = ST_DONE;
                    n_done           = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sweep <= '0;
            r_clr   <= 1'b0;
            r_done  <= 1'b0;
            r_freq  <= FREQ_RESET;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_clr   <= n_clr;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                r_freq <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_addr  <= n_addr;
        r_word  <= n_word;
        r_delta <= n_delta;
        r_sum   <= n_sum;
        r_neg   <= n_neg;
        r_res   <= n_res;
    end

    // Slot store. One item at a time and the write-back edge precedes the
    // next item's read, so no forwarding path is needed.
    slt_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    slt_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (c_start),
        .i_x      (c_x),
        .i_freq   (freq_nz),
        .i_div    (c_div),
        .i_second (c_second),
        .o_done   (c_done),
        .o_quot   (c_quot)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    `SLT_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, o_done, !busy, "result strobe while busy")
    `SLT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy || o_done, "transfer lost")
    `SLT_ASSERT_IMP(a_write_busy, i_clk, i_rst_n, ram_we, busy, "slot write while idle")
    `SLT_ASSERT_IMP(a_conv_state, i_clk, i_rst_n, c_done, (r_state == S_CAVG) || (r_state == S_CMIN) || (r_state == S_CMAX), "stray conversion done")

endmodule
